[hdl/pita_pkg.sv]
// Package for the padded integer to ASCII unit: sizes, states, control struct and character map.
package pita_pkg;

  localparam int MAX_WIDTH  = 63;
  localparam int VALUE_BITS = 64;
  localparam int MAG_BITS   = 64;
  localparam int FW_BITS    = 6;

  // Decimal digit count is ceil(VALUE_BITS * log10(2)).
  localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_BITS   = NDIG * 4;
  localparam int CNT_W      = $clog2(NDIG + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_FILL,
    ST_SIGN,
    ST_DIGITS
  } pita_state_t;

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic dabble;
    logic shift;
  } pita_dig_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + 8'(d);
    end else if (upper) begin
      ch = CH_UPPER + 8'(d - 4'd10);
    end else begin
      ch = CH_LOWER + 8'(d - 4'd10);
    end
    return ch;
  endfunction

endpackage

[hdl/pita_digits.sv]
// Digit register: bit-serial binary to BCD conversion, hex load and digit shift-out.
module pita_digits import pita_pkg::*; (
  input  logic                clk,
  input  pita_dig_ctl_t       ctl,
  input  logic [MAG_BITS-1:0] magnitude,
  output logic [3:0]          top_digit
);

  logic [VALUE_BITS-1:0] mag;
  logic [DIG_BITS-1:0]   digs;
  logic [DIG_BITS-1:0]   adj;

  // Every BCD digit of 5 or more gets 3 added before the doubling shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (digs[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = 4'(digs[4*i +: 4] + 4'd3);
      end else begin
        adj[4*i +: 4] = digs[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_dec) begin
      mag  <= magnitude[VALUE_BITS-1:0];
      digs <= '0;
    end else if (ctl.load_hex) begin
      digs <= DIG_BITS'(magnitude[VALUE_BITS-1:0]);
    end else if (ctl.dabble) begin
      digs <= {adj[DIG_BITS-2:0], mag[VALUE_BITS-1]};
      mag  <= {mag[VALUE_BITS-2:0], 1'b0};
    end else if (ctl.shift) begin
      digs <= {digs[DIG_BITS-5:0], 4'h0};
    end
  end

  assign top_digit = digs[DIG_BITS-1 -: 4];

endmodule

[hdl/padded_integer_to_ascii_unit.sv]
// Top level of the padded integer to ASCII unit: sequencer, padding and character output.
// A decimal word is first converted to BCD bit by bit, a hex word needs no conversion; then up
// to NDIG-1 (19) leading zero digits are dropped and the fill is set up, after which
// one character is formed per cycle and shows on the outputs in the following cycle.
// A new start is taken only once busy drops, so a word is fully output before the next
// one is accepted.
// Synchronous active-high reset returns the sequencer to idle and clears the strobe; the
// receiver cannot stall, and each character is shown for exactly one cycle.
module padded_integer_to_ascii_unit import pita_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MAG_BITS-1:0] magnitude,
  input  logic                base_hex,
  input  logic                upper_case,
  input  logic                negative,
  input  logic [FW_BITS-1:0]  field_width,
  input  logic                zero_fill,
  output logic                char_valid,
  output logic [7:0]          char_out,
  output logic                last_char
);

  pita_state_t          state, state_next;
  pita_dig_ctl_t        dctl;
  logic [3:0]           top_digit;
  logic [BIT_CNT_W-1:0] bitcnt, bitcnt_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [FW_BITS-1:0]   fill, fill_next;
  logic [FW_BITS-1:0]   wcap;
  logic                 neg_r, zpad_r, upper_r;
  logic [FW_BITS-1:0]   width_r;
  logic [6:0]           body;
  logic                 emit;
  logic [7:0]           ch;
  logic                 last;
  logic                 accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  pita_digits u_digits (
    .clk       (clk),
    .ctl       (dctl),
    .magnitude (magnitude),
    .top_digit (top_digit)
  );

  assign body = 7'(cnt) + 7'(neg_r);
  assign wcap = (width_r > FW_BITS'(MAX_WIDTH)) ? FW_BITS'(MAX_WIDTH) : width_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state      <= state_next;
      char_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    bitcnt   <= bitcnt_next;
    cnt      <= cnt_next;
    fill     <= fill_next;
    char_out <= ch;
    last_char <= last;
    if (accept) begin
      neg_r   <= negative;
      zpad_r  <= zero_fill;
      upper_r <= upper_case;
      width_r <= field_width;
    end
  end

  always_comb begin
    state_next  = state;
    bitcnt_next = bitcnt;
    cnt_next    = cnt;
    fill_next   = fill;
    dctl        = '0;
    emit        = 1'b0;
    ch          = CH_SPACE;
    last        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cnt_next    = CNT_W'(NDIG);
          bitcnt_next = BIT_CNT_W'(VALUE_BITS - 1);
          if (base_hex) begin
            dctl.load_hex = 1'b1;
            state_next    = ST_STRIP;
          end else begin
            dctl.load_dec = 1'b1;
            state_next    = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dctl.dabble = 1'b1;
        bitcnt_next = BIT_CNT_W'(bitcnt - 1'b1);
        if (bitcnt == '0) begin
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (top_digit == 4'h0 && cnt > CNT_W'(1)) begin
          dctl.shift = 1'b1;
          cnt_next   = CNT_W'(cnt - 1'b1);
        end else begin
          // Fill only when the capped width exceeds sign plus digits.
          fill_next = (7'(wcap) > body) ? FW_BITS'(7'(wcap) - body) : '0;
          if (zpad_r) begin
            if (neg_r) begin
              state_next = ST_SIGN;
            end else if (7'(wcap) > body) begin
              state_next = ST_FILL;
            end else begin
              state_next = ST_DIGITS;
            end
          end else begin
            if (7'(wcap) > body) begin
              state_next = ST_FILL;
            end else if (neg_r) begin
              state_next = ST_SIGN;
            end else begin
              state_next = ST_DIGITS;
            end
          end
        end
      end
      ST_FILL: begin
        emit      = 1'b1;
        ch        = zpad_r ? CH_ZERO : CH_SPACE;
        fill_next = FW_BITS'(fill - 1'b1);
        if (fill == FW_BITS'(1)) begin
          state_next = (!zpad_r && neg_r) ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        emit = 1'b1;
        ch   = CH_MINUS;
        if (zpad_r && fill != '0) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        emit       = 1'b1;
        ch         = digit_char(top_digit, upper_r);
        dctl.shift = 1'b1;
        cnt_next   = CNT_W'(cnt - 1'b1);
        if (cnt == CNT_W'(1)) begin
          last       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_char && char_valid |-> !busy || $past(state) == ST_DIGITS)
    else $error("last character not produced by the digit phase");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> char_valid && last_char)
    else $error("unit went idle without a final character");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not start the sequencer");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIGITS |-> cnt != '0)
    else $error("digit phase entered with no digits left");

  a_fill_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> fill != '0)
    else $error("fill phase entered with no fill left");

endmodule

[dv/testbench.sv]
// Testbench for the padded integer to ASCII unit: queued command driver, character monitor and predictor.
`timescale 1ns / 1ps

module testbench;
  import pita_pkg::*;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                base_hex;
    logic                upper_case;
    logic                negative;
    logic [FW_BITS-1:0]  field_width;
    logic                zero_fill;
  } number_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [MAG_BITS-1:0] magnitude = '0;
  logic                base_hex = 1'b0;
  logic                upper_case = 1'b0;
  logic                negative = 1'b0;
  logic [FW_BITS-1:0]  field_width = '0;
  logic                zero_fill = 1'b0;
  logic                char_valid;
  logic [7:0]          char_out;
  logic                last_char;

  number_word_t pending_numbers[$];
  text_char_t   expected_text[$];
  number_word_t number_in_flight;

  int mismatches    = 0;
  int numbers_taken = 0;
  int chars_checked = 0;
  int hex_numbers   = 0;
  int longest_text  = 0;

  padded_integer_to_ascii_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .magnitude   (magnitude),
    .base_hex    (base_hex),
    .upper_case  (upper_case),
    .negative    (negative),
    .field_width (field_width),
    .zero_fill   (zero_fill),
    .char_valid  (char_valid),
    .char_out    (char_out),
    .last_char   (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Formats one number the way the unit should and queues its characters.
  function automatic void predict_text(input number_word_t w);
    logic [63:0] value;
    logic [63:0] radix;
    logic [3:0]  d;
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    int          width;
    int          body;
    value = w.magnitude;
    if (VALUE_BITS < 64) begin
      value = value & ((64'd1 << VALUE_BITS) - 64'd1);
    end
    radix = w.base_hex ? 64'd16 : 64'd10;
    width = (int'(w.field_width) > MAX_WIDTH) ? MAX_WIDTH : int'(w.field_width);
    if (value == 64'd0) begin
      digits.push_back(CH_ZERO);
    end
    while (value != 64'd0) begin
      d = 4'(value % radix);
      if (d < 4'd10) begin
        digits.push_back(8'h30 + 8'(d));
      end else begin
        digits.push_back((w.upper_case ? 8'h41 : 8'h61) + 8'(d) - 8'd10);
      end
      value = value / radix;
    end
    body = digits.size() + (w.negative ? 1 : 0);
    if (w.zero_fill) begin
      if (w.negative) text.push_back(CH_MINUS);
      for (int i = body; i < width; i++) text.push_back(CH_ZERO);
    end else begin
      for (int i = body; i < width; i++) text.push_back(CH_SPACE);
      if (w.negative) text.push_back(CH_MINUS);
    end
    while (digits.size() > 0) begin
      text.push_back(digits.pop_back());
    end
    foreach (text[i]) begin
      expected_text.push_back('{ch: text[i], last: (i == text.size() - 1)});
    end
    if (text.size() > longest_text) longest_text = text.size();
  endfunction

  task automatic add_number(input logic [63:0] mag, input logic hex, input logic up,
                            input logic neg, input int fw, input logic zp);
    pending_numbers.push_back('{magnitude: mag, base_hex: hex, upper_case: up,
                                negative: neg, field_width: FW_BITS'(fw), zero_fill: zp});
  endtask

  // Driver: a word is taken when start is high and busy is low. The idle-free
  // window in the middle lets words follow each other as fast as possible.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_text(number_in_flight);
        numbers_taken++;
        if (number_in_flight.base_hex) hex_numbers++;
      end
      if (!start || !busy) begin
        if (pending_numbers.size() > 0 &&
            ((numbers_taken >= 140 && numbers_taken < 200) || $urandom_range(99) >= 29)) begin
          number_in_flight = pending_numbers.pop_front();
          start       <= 1'b1;
          magnitude   <= number_in_flight.magnitude;
          base_hex    <= number_in_flight.base_hex;
          upper_case  <= number_in_flight.upper_case;
          negative    <= number_in_flight.negative;
          field_width <= number_in_flight.field_width;
          zero_fill   <= number_in_flight.zero_fill;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed character is compared with the oldest expected one.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && char_valid) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", char_out, last_char));
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (char_out !== want.ch) begin
          report_mismatch($sformatf("char_out %h, predicted %h", char_out, want.ch));
        end
        if (last_char !== want.last) begin
          report_mismatch($sformatf("last_char %b, predicted %b (char %h)",
                                    last_char, want.last, want.ch));
        end
      end
    end
  end

  initial begin
    logic [63:0] mag;
    int          fw;
    // Directed words: extremes, both bases and cases, both paddings, negative zero,
    // negative hex, bodies longer than the width and the widest field.
    add_number(64'd0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_number(64'd0, 1'b1, 1'b1, 1'b0, 0, 1'b1);
    add_number(64'd0, 1'b0, 1'b0, 1'b1, 0, 1'b0);
    add_number(64'd0, 1'b0, 1'b0, 1'b1, 6, 1'b1);
    add_number(64'd0, 1'b1, 1'b0, 1'b1, 6, 1'b0);
    add_number('1, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_number('1, 1'b0, 1'b1, 1'b1, 5, 1'b1);
    add_number('1, 1'b1, 1'b1, 1'b0, 0, 1'b0);
    add_number('1, 1'b1, 1'b0, 1'b1, 63, 1'b1);
    add_number('1, 1'b0, 1'b0, 1'b1, 63, 1'b0);
    add_number(64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1'b0, 1'b1, 20, 1'b0);
    add_number(64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1'b1, 1'b0, 20, 1'b1);
    add_number(64'd1234567890, 1'b0, 1'b1, 1'b0, 12, 1'b0);
    add_number(64'd1234567890, 1'b0, 1'b0, 1'b1, 12, 1'b1);
    add_number(64'd42, 1'b0, 1'b0, 1'b1, 3, 1'b1);
    add_number(64'd42, 1'b0, 1'b0, 1'b1, 2, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 1, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b1, 63, 1'b1);
    add_number(64'd9, 1'b0, 1'b0, 1'b0, 63, 1'b0);
    add_number(64'hA, 1'b1, 1'b1, 1'b1, 63, 1'b0);
    add_number(64'hF, 1'b1, 1'b0, 1'b0, 63, 1'b1);
    add_number(64'd10, 1'b0, 1'b1, 1'b0, 1, 1'b1);
    add_number(64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0, 0, 1'b0);
    add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b1, 40, 1'b1);
    for (int n = 0; n < 290; n++) begin
      case ($urandom_range(9))
        0:       mag = 64'd0;
        1:       mag = 64'($urandom_range(20));
        2:       mag = '1;
        3, 4, 5: mag = {$urandom, $urandom} >> $urandom_range(63);
        default: mag = {$urandom, $urandom};
      endcase
      fw = ($urandom_range(9) < 4) ? $urandom_range(24) : $urandom_range(63);
      add_number(mag, 1'($urandom), 1'($urandom), 1'($urandom), fw, 1'($urandom));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending_numbers.size() != 0 || start || expected_text.size() != 0);
    repeat (200) @(negedge clk);

    $display("Converted %0d numbers (%0d in hex) into %0d checked characters.",
             numbers_taken, hex_numbers, chars_checked);
    $display("Longest text was %0d characters; %0d mismatches counted.",
             longest_text, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: %0d numbers still queued, %0d characters outstanding.",
             pending_numbers.size(), expected_text.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/pita_pkg.sv
hdl/pita_digits.sv
hdl/padded_integer_to_ascii_unit.sv
dv/testbench.sv
